// File: rtl/bmm_pkg.sv
// shared types, constants and address helpers of the banked memory map
package bmm_pkg;

  localparam int unsigned RAM_BYTES = 65536;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);

  localparam int unsigned BASIC_BYTES  = 8192;
  localparam int unsigned KERNAL_BYTES = 8192;
  localparam int unsigned CHAR_BYTES   = 4096;

  localparam int unsigned BASIC_BASE  = 0;
  localparam int unsigned KERNAL_BASE = BASIC_BASE + BASIC_BYTES;
  localparam int unsigned CHAR_BASE   = KERNAL_BASE + KERNAL_BYTES;
  localparam int unsigned ROM_DEPTH   = CHAR_BASE + CHAR_BYTES;
  localparam int unsigned ROM_AW      = $clog2(ROM_DEPTH);

  localparam int unsigned INIT_W = RAM_AW + 1;

  localparam logic [7:0] FILL_BYTE  = 8'hEA;
  localparam logic [7:0] RAM_BYTE0  = 8'h2F;
  localparam logic [7:0] RAM_BYTE1  = 8'h37;
  localparam logic [RAM_AW-1:0] PORT_ADDR = RAM_AW'(1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ROM_BASIC  = 2'd0,
    ROM_KERNAL = 2'd1,
    ROM_CHAR   = 2'd2
  } rom_sel_e;

  typedef struct packed {
    logic char_on;
    logic io_on;
    logic kernal_on;
    logic basic_on;
  } bank_flags_t;

  typedef struct packed {
    logic              busy;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_data;
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic [7:0]        rom_data;
  } init_t;

  function automatic logic [ROM_AW-1:0] basic_addr(input logic [15:0] a);
    return ROM_AW'(BASIC_BASE) + ROM_AW'(a[12:0]);
  endfunction

  function automatic logic [ROM_AW-1:0] kernal_addr(input logic [15:0] a);
    return ROM_AW'(KERNAL_BASE) + ROM_AW'(a[12:0]);
  endfunction

  function automatic logic [ROM_AW-1:0] char_addr(input logic [15:0] a);
    return ROM_AW'(CHAR_BASE) + ROM_AW'(a[11:0]);
  endfunction

  function automatic logic [7:0] ram_init(input logic [RAM_AW-1:0] a);
    logic [7:0] v;
    case (a)
      RAM_AW'(0): v = RAM_BYTE0;
      RAM_AW'(1): v = RAM_BYTE1;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] rom_init(input logic [ROM_AW-1:0] a);
    logic [7:0] v;
    if (a < ROM_AW'(KERNAL_BASE)) begin
      v = FILL_BYTE;
    end else if (a < ROM_AW'(CHAR_BASE)) begin
      // nmi, reset and irq vectors at the top of the kernal
      case (a[12:0])
        13'h1FFA: v = 8'h43;
        13'h1FFB: v = 8'hFE;
        13'h1FFC: v = 8'h00;
        13'h1FFD: v = 8'hE0;
        13'h1FFE: v = 8'h48;
        13'h1FFF: v = 8'hFF;
        default:  v = FILL_BYTE;
      endcase
    end else begin
      v = 8'h00;
    end
    return v;
  endfunction

endpackage

// File: rtl/bmm_if.sv
// valid/ready channels carrying request and response words
interface bmm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [15:0] address;
  logic [7:0] write_data;
  logic [1:0] rom_select;

  modport source (output valid, op, address, write_data, rom_select, input ready);
  modport sink   (input valid, op, address, write_data, rom_select, output ready);
endinterface

interface bmm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       basic_on;
  logic       kernal_on;
  logic       io_on;
  logic       char_on;

  modport source (output valid, read_data, basic_on, kernal_on, io_on, char_on,
                  input ready);
  modport sink   (input valid, read_data, basic_on, kernal_on, io_on, char_on,
                  output ready);
endinterface

// File: rtl/bmm_sp_ram.sv
// single-port synchronous ram with registered read data
module bmm_sp_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

// File: rtl/bmm_init.sv
// clearing pass that loads reset contents into ram and rom stores
module bmm_init (
  input  logic          clk_i,
  input  logic          rst_ni,
  output bmm_pkg::init_t init_o
);
  import bmm_pkg::*;

  logic [INIT_W-1:0] cnt_q, cnt_d;
  logic              busy;

  assign busy  = !cnt_q[INIT_W-1];
  assign cnt_d = busy ? cnt_q + INIT_W'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    init_o.busy     = busy;
    init_o.ram_we   = busy;
    init_o.ram_addr = cnt_q[RAM_AW-1:0];
    init_o.ram_data = ram_init(cnt_q[RAM_AW-1:0]);
    init_o.rom_we   = busy && (cnt_q[RAM_AW-1:0] < RAM_AW'(ROM_DEPTH));
    init_o.rom_addr = cnt_q[ROM_AW-1:0];
    init_o.rom_data = rom_init(cnt_q[ROM_AW-1:0]);
  end

endmodule

// File: rtl/banked_memory_map.sv
// top level of the banked memory map: decode, memory access and response
// banked 64k memory with basic, kernal and character rom overlays
// in_i takes one word per operation: read, write or rom byte load
// out_o returns one word per operation: the byte read (zero otherwise)
// and the four bank flags as they stand after that operation
// an accepted word passes through the read stage, where the ram or rom
// registers its read data, and then through the output register
// one word per cycle is sustained while the receiver keeps taking responses
// writes outside an active rom overlay and loads with a valid rom select
// go to memory in the cycle they are accepted, so a read in the next
// cycle already sees them; after reset a clearing pass loads the reset
// contents, and in_i.ready stays low until it is done
// when the receiver stalls, the response is held in the output register,
// one further word waits in the read stage, then in_i.ready drops
// bank flags reset to all on
module banked_memory_map (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmm_in_if.sink    in_i,
  bmm_out_if.source out_o
);
  import bmm_pkg::*;

  init_t       init;
  bank_flags_t flags_q, flags_d;

  logic        s1_q, s1_read_q, s1_rom_q;
  bank_flags_t s1_flags_q;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  bank_flags_t out_flags_q;

  logic        s1_move, acc;
  logic        basic_hit, kernal_hit, char_hit, rom_hit;
  logic        is_read, is_write, is_load;
  logic        wr_ok, load_ok;
  logic [ROM_AW-1:0] bus_rom_addr, load_rom_addr;

  logic              ram_we, ram_re, rom_we, rom_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [ROM_AW-1:0] rom_addr;
  logic [7:0]        ram_wdata, rom_wdata, ram_rdata, rom_rdata;

  bmm_init u_init (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_o (init)
  );

  assign s1_move    = s1_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !init.busy && (!s1_q || s1_move);
  assign acc        = in_i.valid && in_i.ready;

  assign is_read  = (in_i.op == OP_READ);
  assign is_write = (in_i.op == OP_WRITE);
  assign is_load  = (in_i.op == OP_LOAD);

  assign basic_hit  = (in_i.address[15:13] == 3'b101) && flags_q.basic_on;
  assign kernal_hit = (in_i.address[15:13] == 3'b111) && flags_q.kernal_on;
  assign char_hit   = (in_i.address[15:12] == 4'hD) && !flags_q.io_on &&
                      flags_q.char_on;
  assign rom_hit    = basic_hit || kernal_hit || char_hit;

  always_comb begin
    if (basic_hit) begin
      bus_rom_addr = basic_addr(in_i.address);
    end else if (kernal_hit) begin
      bus_rom_addr = kernal_addr(in_i.address);
    end else begin
      bus_rom_addr = char_addr(in_i.address);
    end
  end

  always_comb begin
    load_ok = 1'b1;
    case (in_i.rom_select)
      ROM_BASIC:  load_rom_addr = basic_addr(in_i.address);
      ROM_KERNAL: load_rom_addr = kernal_addr(in_i.address);
      ROM_CHAR:   load_rom_addr = char_addr(in_i.address);
      default: begin
        load_rom_addr = char_addr(in_i.address);
        load_ok       = 1'b0;
      end
    endcase
  end

  assign wr_ok = acc && is_write && !rom_hit;

  assign ram_we    = init.ram_we || wr_ok;
  assign ram_re    = acc && is_read && !rom_hit;
  assign ram_addr  = init.busy ? init.ram_addr : in_i.address[RAM_AW-1:0];
  assign ram_wdata = init.busy ? init.ram_data : in_i.write_data;

  assign rom_we    = init.rom_we || (acc && is_load && load_ok);
  assign rom_re    = acc && is_read && rom_hit;
  assign rom_addr  = init.busy ? init.rom_addr : (is_load ? load_rom_addr : bus_rom_addr);
  assign rom_wdata = init.busy ? init.rom_data : in_i.write_data;

  bmm_sp_ram #(.DEPTH(RAM_BYTES), .WIDTH(8)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bmm_sp_ram #(.DEPTH(ROM_DEPTH), .WIDTH(8)) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .re_i    (rom_re),
    .addr_i  (rom_addr),
    .wdata_i (rom_wdata),
    .rdata_o (rom_rdata)
  );

  always_comb begin
    flags_d = flags_q;
    if (wr_ok && in_i.address[RAM_AW-1:0] == PORT_ADDR) begin
      flags_d.kernal_on = in_i.write_data[1];
      flags_d.basic_on  = |in_i.write_data[1:0];
      flags_d.io_on     = in_i.write_data[2];
      flags_d.char_on   = !in_i.write_data[2] && (|in_i.write_data[1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '1;
      s1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flags_q <= flags_d;
      if (acc) begin
        s1_q <= 1'b1;
      end else if (s1_move) begin
        s1_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_read_q  <= is_read;
      s1_rom_q   <= rom_hit;
      s1_flags_q <= flags_d;
    end
    if (s1_move) begin
      out_data_q  <= !s1_read_q ? 8'h00 : (s1_rom_q ? rom_rdata : ram_rdata);
      out_flags_q <= s1_flags_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.basic_on  = out_flags_q.basic_on;
  assign out_o.kernal_on = out_flags_q.kernal_on;
  assign out_o.io_on     = out_flags_q.io_on;
  assign out_o.char_on   = out_flags_q.char_on;

  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init.busy |-> !acc)
    else $error("word accepted during clearing pass");

  a_port_write_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && is_write && in_i.address == 16'h0001 |=>
      flags_q.io_on == $past(in_i.write_data[2]) &&
      flags_q.kernal_on == $past(in_i.write_data[1]))
    else $error("bank flags not updated by port write");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q && out_valid_q && !out_o.ready |=> s1_q && out_valid_q)
    else $error("pending word lost while receiver stalled");

  a_flags_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_ok |=> $stable(flags_q))
    else $error("bank flags changed without a write");

endmodule
